@@ hdl/rrrq_pkg.sv @@
// Shared constants and types for the round-robin run queue.
package rrrq_pkg;

	localparam int MAX_PROCS = 8;
	localparam int IDX_W     = $clog2(MAX_PROCS);
	localparam int CNT_W     = $clog2(MAX_PROCS + 1);
	localparam int ID_W      = 3;
	localparam int NUM_IDS   = 1 << ID_W;
	localparam int CAP_W     = 4;
	localparam int ACT_W     = 2;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

	localparam logic [PADDR_W-1:0] ADDR_CAPACITY = PADDR_W'(0);

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_ROTATE = 2'd2
	} action_t;

	typedef logic [ID_W-1:0] pid_t;

endpackage

@@ hdl/round_robin_run_queue_unit.sv @@
// Round-robin run queue: ordered process id queue with add, remove and rotate.
//
// Input channel (in_valid / in_stall) carries one request per transaction:
// action, proc_id, has_parent, parent_id. Output channel (out_valid /
// out_stall) returns exactly one result per request: status and a snapshot
// of current process, queue head and queue count after the action.
// A request taken is held in an input register, then applied to the queue
// when the result register is loaded. While the receiver does not stall,
// one request per cycle is sustained; the queue update is a single
// compare-and-shift over the MAX_PROCS entries between the input register
// and the result register. When the receiver stalls, the result register
// holds; the input register keeps its request and in_stall rises until the
// result register frees up. Reset empties the queue, clears parents and the
// current process and sets capacity to its reset value. Capacity is written
// over the APB port at byte address 0; the user must write it only while the
// block is idle, and the block itself does not enforce this. Values above
// MAX_PROCS act as MAX_PROCS, and zero refuses every add.
module round_robin_run_queue_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rrrq_pkg::PADDR_W-1:0]  paddr,
	input  logic [rrrq_pkg::PDATA_W-1:0]  pwdata,
	output logic [rrrq_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rrrq_pkg::ACT_W-1:0]    action,
	input  logic [rrrq_pkg::ID_W-1:0]     proc_id,
	input  logic                          has_parent,
	input  logic [rrrq_pkg::ID_W-1:0]     parent_id,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          status,
	output logic                          current_valid,
	output logic [rrrq_pkg::ID_W-1:0]     current_id,
	output logic                          head_valid,
	output logic [rrrq_pkg::ID_W-1:0]     head_id,
	output logic [rrrq_pkg::CNT_W-1:0]    queue_count
);
	import rrrq_pkg::*;

	// configuration
	logic [CAP_W-1:0] capacity_q;
	logic             cfg_wr;

	// input register
	logic             valid_s1;
	logic [ACT_W-1:0] action_s1;
	pid_t             id_s1;
	logic             has_par_s1;
	pid_t             par_s1;

	// queue state
	pid_t             order_q [MAX_PROCS];
	logic [CNT_W-1:0] size_q;
	logic [ID_W:0]    parent_q [NUM_IDS];
	logic             cur_valid_q;
	pid_t             cur_id_q;

	// next-state logic
	logic [MAX_PROCS-1:0] match;
	logic [IDX_W-1:0]     pos;
	logic                 found;
	logic                 ok;
	logic                 advance;
	logic                 commit;
	logic                 par_wr;
	pid_t                 nxt_order [MAX_PROCS];
	logic [CNT_W-1:0]     nxt_size;
	logic                 nxt_cur_valid;
	pid_t                 nxt_cur_id;
	logic [ID_W:0]        rm_parent;
	logic [IDX_W-1:0]     last_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_CAPACITY) begin
			prdata = PDATA_W'(capacity_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr && paddr == ADDR_CAPACITY) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// handshake
	assign advance  = !out_valid || !out_stall;
	assign commit   = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			action_s1  <= action;
			id_s1      <= proc_id;
			has_par_s1 <= has_parent;
			par_s1     <= parent_id;
		end
	end

	// search the live part of the queue
	always_comb begin
		for (int i = 0; i < MAX_PROCS; i++) begin
			match[i] = (CNT_W'(i) < size_q) && (order_q[i] == id_s1);
		end
		found = |match;
		pos   = '0;
		for (int i = MAX_PROCS - 1; i >= 0; i--) begin
			if (match[i]) begin
				pos = IDX_W'(i);
			end
		end
	end

	assign rm_parent = parent_q[id_s1];
	assign last_idx  = IDX_W'(size_q - CNT_W'(1));

	always_comb begin
		nxt_order     = order_q;
		nxt_size      = size_q;
		nxt_cur_valid = cur_valid_q;
		nxt_cur_id    = cur_id_q;
		ok            = 1'b0;
		par_wr        = 1'b0;
		case (action_s1)
			ACT_ADD: begin
				if (int'(size_q) < int'(capacity_q) && int'(size_q) < MAX_PROCS && !found) begin
					ok                             = 1'b1;
					par_wr                         = 1'b1;
					nxt_order[size_q[IDX_W-1:0]]   = id_s1;
					nxt_size                       = size_q + CNT_W'(1);
					nxt_cur_valid                  = 1'b1;
					nxt_cur_id                     = id_s1;
				end
			end
			ACT_REMOVE: begin
				if (found) begin
					ok = 1'b1;
					for (int i = 0; i < MAX_PROCS - 1; i++) begin
						if (IDX_W'(i) >= pos) begin
							nxt_order[i] = order_q[i+1];
						end
					end
					nxt_size = size_q - CNT_W'(1);
					if (rm_parent[ID_W]) begin
						nxt_cur_valid = 1'b1;
						nxt_cur_id    = rm_parent[ID_W-1:0];
					end else if (nxt_size != '0) begin
						nxt_cur_valid = 1'b1;
						nxt_cur_id    = nxt_order[0];
					end else begin
						nxt_cur_valid = 1'b0;
						nxt_cur_id    = '0;
					end
				end
			end
			ACT_ROTATE: begin
				if (size_q != '0) begin
					ok = 1'b1;
					for (int i = 0; i < MAX_PROCS - 1; i++) begin
						nxt_order[i] = order_q[i+1];
					end
					nxt_order[last_idx] = order_q[0];
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// queue contents past the count are never read
	always_ff @(posedge clk) begin
		if (commit) begin
			order_q <= nxt_order;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q      <= '0;
			cur_valid_q <= 1'b0;
			cur_id_q    <= '0;
			for (int i = 0; i < NUM_IDS; i++) begin
				parent_q[i] <= '0;
			end
		end else if (commit) begin
			size_q      <= nxt_size;
			cur_valid_q <= nxt_cur_valid;
			cur_id_q    <= nxt_cur_id;
			if (par_wr) begin
				parent_q[id_s1] <= has_par_s1 ? {1'b1, par_s1} : '0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status        <= !ok;
			current_valid <= nxt_cur_valid;
			current_id    <= nxt_cur_valid ? nxt_cur_id : '0;
			head_valid    <= nxt_size != '0;
			head_id       <= (nxt_size != '0) ? nxt_order[0] : '0;
			queue_count   <= nxt_size;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(size_q) <= MAX_PROCS)
		else $error("queue count above MAX_PROCS");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (size_q == $past(size_q) || size_q == $past(size_q) + CNT_W'(1)
			|| size_q == $past(size_q) - CNT_W'(1)))
		else $error("queue count moved by more than one");

	a_current_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		size_q != '0 |-> cur_valid_q)
		else $error("nonempty queue without a current process");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (head_valid == (queue_count != '0)))
		else $error("head_valid disagrees with queue_count");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked transaction");
`endif

endmodule
